// ===== src/tlbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbp_pkg
// Shared types, constants and helpers of the two-level branch predictor.
// ----------------------------------------------------------------------------
package tlbp_pkg;

   localparam int MAX_PC_BITS      = 10;
   localparam int MAX_HISTORY_BITS = 4;

   localparam int CTR_WIDTH   = 2;
   localparam int ROW_WIDTH   = CTR_WIDTH << MAX_HISTORY_BITS;
   localparam int TABLE_ROWS  = 1 << MAX_PC_BITS;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PC_BITS      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HISTORY_BITS = 2'd1;

   localparam logic [3:0] PC_BITS_RESET      = 4'd10;
   localparam logic [2:0] HISTORY_BITS_RESET = 3'd4;

   localparam logic [CTR_WIDTH-1:0] CTR_ST = 2'd3;
   localparam logic [CTR_WIDTH-1:0] CTR_WT = 2'd2;
   localparam logic [CTR_WIDTH-1:0] CTR_WN = 2'd1;
   localparam logic [CTR_WIDTH-1:0] CTR_SN = 2'd0;

   localparam logic [ROW_WIDTH-1:0] CLEAR_ROW = {(1 << MAX_HISTORY_BITS){CTR_WT}};

   typedef logic [MAX_PC_BITS-1:0]      row_addr_type;
   typedef logic [MAX_HISTORY_BITS-1:0] col_addr_type;
   typedef logic [ROW_WIDTH-1:0]        row_data_type;

   typedef struct packed {
      logic         en;
      row_addr_type row;
      row_data_type data;
   } tbl_write_type;

   function automatic row_addr_type pc_mask(input logic [3:0] n);
      row_addr_type m;
      for (int i = 0; i < MAX_PC_BITS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   function automatic col_addr_type history_mask(input logic [2:0] n);
      col_addr_type m;
      for (int i = 0; i < MAX_HISTORY_BITS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   function automatic logic [CTR_WIDTH-1:0] ctr_next(input logic [CTR_WIDTH-1:0] ctr,
                                                      input logic taken);
      logic [CTR_WIDTH-1:0] r;
      r = CTR_WT;
      if (taken) begin
         case (ctr)
            CTR_ST, CTR_WT, CTR_WN: r = CTR_ST;
            default:                r = CTR_WN;
         endcase
      end else begin
         case (ctr)
            CTR_SN, CTR_WN, CTR_WT: r = CTR_SN;
            default:                r = CTR_WT;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== src/tlbp_table.sv =====
// ----------------------------------------------------------------------------
// tlbp_table
// Counter table: one row of counters per address index, one synchronous
// read port and one write port, with a row-by-row clearing pass after reset.
// ----------------------------------------------------------------------------
module tlbp_table import tlbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  row_addr_type  rd_row,
   output row_data_type  rd_data,
   input  tbl_write_type wr,
   output logic          busy
);

   row_data_type mem [TABLE_ROWS];
   row_data_type rd_data_ff;
   logic         clear_ff;
   logic         clear_in;
   row_addr_type clear_row_ff;
   row_addr_type clear_row_in;

   always_comb begin
      clear_in     = clear_ff;
      clear_row_in = clear_row_ff;
      if (clear_ff) begin
         clear_row_in = clear_row_ff + row_addr_type'(1);
         if (clear_row_ff == {MAX_PC_BITS{1'b1}}) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_row_ff <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_row_ff <= clear_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clear_row_ff] <= CLEAR_ROW;
      end else if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clear_ff;

endmodule

// ===== src/two_level_branch_predictor_unit.sv =====
// ----------------------------------------------------------------------------
// two_level_branch_predictor_unit
// Two-level branch predictor with 2-bit hysteresis counters and global history.
// ----------------------------------------------------------------------------
// Request channel (req_): one resolved branch per transaction, its address and
// actual outcome. Response channel (rsp_): the prediction made from the counter
// before the update, a mispredict flag and the running miss count.
// Configuration (csr_): write csr_data to register csr_index (0 pc_bits,
// 1 history_bits) while the unit is idle; other indexes are ignored.
//
// An accepted request is registered in the work stage, its counter table row
// read from the table; when that stage advances, the response is loaded into
// the output register. Throughput: one transaction per cycle while no response
// is stalled; the row is read in the accept cycle and written back on advance,
// with the last write forwarded to the following read of the same row.
//
// Reset: synchronous. The counter table is then cleared to weakly taken one
// row per cycle, all 1024 rows, with req_stall held high throughout.
// When rsp_stall is high the response holds, the work stage fills, and then
// req_stall rises until the response is taken.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_unit import tlbp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_branch_address,
   input  logic                       req_taken,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_predict_taken,
   output logic                       rsp_mispredicted,
   output logic [31:0]                rsp_miss_count,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [3:0]    pc_bits_ff, pc_bits_in;
   logic [2:0]    history_bits_ff, history_bits_in;
   col_addr_type  hist_ff, hist_in;
   logic          s1_valid_ff, s1_valid_in;
   row_addr_type  s1_row_ff;
   col_addr_type  s1_col_ff;
   logic          s1_taken_ff;
   logic          fwd_valid_ff, fwd_valid_in;
   row_addr_type  fwd_row_ff;
   row_data_type  fwd_data_ff;
   logic [31:0]   miss_total_ff, miss_total_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pred_ff;
   logic          rsp_miss_ff;
   logic [31:0]   rsp_count_ff;

   logic          busy;
   logic          accept;
   logic          advance;
   row_addr_type  row_idx;
   col_addr_type  col_idx;
   col_addr_type  hmask;
   row_data_type  rd_data;
   row_data_type  row_cur;
   row_data_type  row_new;
   logic [CTR_WIDTH-1:0] ctr;
   logic          pred;
   logic          miss;
   tbl_write_type wr;

   tlbp_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_row  (row_idx),
      .rd_data (rd_data),
      .wr      (wr),
      .busy    (busy)
   );

   always_comb begin
      pc_bits_in      = pc_bits_ff;
      history_bits_in = history_bits_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PC_BITS:      pc_bits_in      = csr_data;
            CSR_HISTORY_BITS: history_bits_in = csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign hmask   = history_mask(history_bits_ff);
   assign row_idx = req_branch_address[MAX_PC_BITS-1:0] & pc_mask(pc_bits_ff);
   assign col_idx = hist_ff & hmask;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign hist_in = accept ? ({hist_ff[MAX_HISTORY_BITS-2:0], req_taken} & hmask) : hist_ff;

   // take the newest copy of the row: the write-back at the read edge is missed
   assign row_cur = (fwd_valid_ff && (fwd_row_ff == s1_row_ff)) ? fwd_data_ff : rd_data;
   assign ctr     = row_cur[{s1_col_ff, 1'b0} +: CTR_WIDTH];
   assign pred    = ctr[1];
   assign miss    = pred ^ s1_taken_ff;

   always_comb begin
      row_new = row_cur;
      row_new[{s1_col_ff, 1'b0} +: CTR_WIDTH] = ctr_next(ctr, s1_taken_ff);
   end

   assign wr.en   = advance;
   assign wr.row  = s1_row_ff;
   assign wr.data = row_new;

   assign miss_total_in = advance ? (miss_total_ff + {31'd0, miss}) : miss_total_ff;
   assign fwd_valid_in  = fwd_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_bits_ff      <= PC_BITS_RESET;
         history_bits_ff <= HISTORY_BITS_RESET;
         hist_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         miss_total_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pc_bits_ff      <= pc_bits_in;
         history_bits_ff <= history_bits_in;
         hist_ff         <= hist_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         miss_total_ff   <= miss_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff   <= row_idx;
         s1_col_ff   <= col_idx;
         s1_taken_ff <= req_taken;
      end
      if (advance) begin
         fwd_row_ff   <= s1_row_ff;
         fwd_data_ff  <= row_new;
         rsp_pred_ff  <= pred;
         rsp_miss_ff  <= miss;
         rsp_count_ff <= miss_total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predict_taken = rsp_pred_ff;
   assign rsp_mispredicted  = rsp_miss_ff;
   assign rsp_miss_count    = rsp_count_ff;

endmodule

// ===== src/tlbp_checker.sv =====
// ----------------------------------------------------------------------------
// tlbp_checker
// Port-level checks of the branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module tlbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_predict_taken,
   input logic        rsp_mispredicted,
   input logic [31:0] rsp_miss_count
);

   logic        seen_ff;
   logic [31:0] last_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         last_count_ff <= rsp_miss_count;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("unit not held busy and empty after reset");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |-> rsp_miss_count == last_count_ff + {31'd0, rsp_mispredicted})
      else $error("miss count does not follow the mispredict flags");

   a_first_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !seen_ff |-> rsp_miss_count == {31'd0, rsp_mispredicted})
      else $error("first miss count after reset is wrong");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_predict_taken)
         && $stable(rsp_mispredicted) && $stable(rsp_miss_count))
      else $error("stalled response changed");

endmodule

bind two_level_branch_predictor_unit tlbp_checker u_tlbp_checker (.*);
